### src/nzmms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nzmms_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int PIXEL_BITS = 8;
  localparam int OUT_MAX = 255;
  localparam int PROD_BITS = SAMPLE_BITS + PIXEL_BITS;
  localparam int STEP_CNT_BITS = $clog2(PIXEL_BITS + 1);

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_MEASURE = 2'd1;
  localparam logic [1:0] MODE_SCALE = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  range_valid;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic measure;
  } stats_cmd_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] low_mark;
    logic [SAMPLE_BITS-1:0] high_mark;
    logic                   seen_any;
    logic                   range_ok;
  } stats_t;

  typedef struct packed {
    logic                  done;
    logic [PIXEL_BITS-1:0] quotient;
  } div_sts_t;

endpackage

`default_nettype wire

### src/nzmms_stats.sv
`timescale 1ns / 1ps
`default_nettype none

module nzmms_stats (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire nzmms_pkg::stats_cmd_t               cmd,
  input  wire logic [nzmms_pkg::SAMPLE_BITS-1:0]   sample,
  output nzmms_pkg::stats_t                        stats
);

  logic [nzmms_pkg::SAMPLE_BITS-1:0] low_r, low_nxt;
  logic [nzmms_pkg::SAMPLE_BITS-1:0] high_r, high_nxt;
  logic                              seen_r, seen_nxt;

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    seen_nxt = seen_r;
    if (cmd.clear) begin
      low_nxt  = '1;
      high_nxt = '0;
      seen_nxt = 1'b0;
    end else if (cmd.measure && (sample != '0)) begin
      if (sample < low_r) begin
        low_nxt = sample;
      end
      if (sample > high_r) begin
        high_nxt = sample;
      end
      seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '1;
      high_r <= '0;
      seen_r <= 1'b0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      seen_r <= seen_nxt;
    end
  end

  assign stats.low_mark  = low_r;
  assign stats.high_mark = high_r;
  assign stats.seen_any  = seen_r;
  assign stats.range_ok  = seen_r && (high_r > low_r);

endmodule

`default_nettype wire

### src/nzmms_div.sv
`timescale 1ns / 1ps
`default_nettype none

module nzmms_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [nzmms_pkg::PROD_BITS-1:0]     num,
  input  wire logic [nzmms_pkg::SAMPLE_BITS-1:0]   den,
  output nzmms_pkg::div_sts_t                      sts
);

  localparam int SB = nzmms_pkg::SAMPLE_BITS;
  localparam int PB = nzmms_pkg::PIXEL_BITS;
  localparam int CB = nzmms_pkg::STEP_CNT_BITS;

  logic [CB-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [SB-1:0] rem_r, rem_nxt;
  logic [PB-1:0] quo_r, quo_nxt;
  logic [SB-1:0] den_r, den_nxt;
  logic [SB:0]   trial;
  logic [SB:0]   trial_sub;
  logic          ge;

  assign trial     = {rem_r, quo_r[PB-1]};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      rem_nxt = num[nzmms_pkg::PROD_BITS-1:PB];
      quo_nxt = num[PB-1:0];
      den_nxt = den;
      cnt_nxt = CB'(PB);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? trial_sub[SB-1:0] : trial[SB-1:0];
      quo_nxt  = {quo_r[PB-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CB'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

`default_nettype wire

### src/nonzero_minmax_stretch_to_byte_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Clear and measure transfers are taken one per cycle and give no result.
// A scale transfer that needs the divider runs PREP, MUL, DIV (the 8-step restoring
// divider) and DONE; other scale transfers go from PREP straight to DONE.
// The input stalls while a scale item is in work; one item is in work at a time.
// Synchronous active-low reset empties the statistics and the output register.

module nonzero_minmax_stretch_to_byte_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire nzmms_pkg::in_item_t  in_payload,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output nzmms_pkg::out_item_t      out_payload
);

  localparam int SB = nzmms_pkg::SAMPLE_BITS;
  localparam int PB = nzmms_pkg::PIXEL_BITS;
  localparam int RB = nzmms_pkg::PROD_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [SB-1:0] v_r, v_nxt;
  logic          valid_r, valid_nxt;
  logic [SB-1:0] diff_r, diff_nxt;
  logic [SB-1:0] den_r, den_nxt;
  logic [PB-1:0] pix_r, pix_nxt;
  logic          out_valid_r, out_valid_nxt;
  nzmms_pkg::out_item_t out_item_r, out_item_nxt;

  logic                  in_xfer;
  nzmms_pkg::stats_cmd_t stats_cmd;
  nzmms_pkg::stats_t     stats;
  nzmms_pkg::div_sts_t   div_sts;
  logic                  div_start;
  logic [RB-1:0]         div_num;
  logic                  out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign stats_cmd.clear   = in_xfer && (in_payload.mode == nzmms_pkg::MODE_CLEAR);
  assign stats_cmd.measure = in_xfer && (in_payload.mode == nzmms_pkg::MODE_MEASURE);

  nzmms_stats u_stats (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (stats_cmd),
    .sample (in_payload.sample),
    .stats  (stats)
  );

  assign div_start = (state_r == ST_MUL);
  assign div_num   = RB'(diff_r) * RB'(nzmms_pkg::OUT_MAX);

  nzmms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .sts   (div_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    valid_nxt     = valid_r;
    diff_nxt      = diff_r;
    den_nxt       = den_r;
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_payload.mode == nzmms_pkg::MODE_SCALE)) begin
          v_nxt     = in_payload.sample;
          valid_nxt = stats.range_ok;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        diff_nxt = v_r - stats.low_mark;
        den_nxt  = stats.high_mark - stats.low_mark;
        if ((v_r == '0) || !valid_r || (v_r <= stats.low_mark)) begin
          pix_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (v_r >= stats.high_mark) begin
          pix_nxt   = PB'(nzmms_pkg::OUT_MAX);
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          pix_nxt   = div_sts.quotient;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.pixel       = pix_r;
          out_item_nxt.range_valid = valid_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    valid_r    <= valid_nxt;
    diff_r     <= diff_nxt;
    den_r      <= den_nxt;
    pix_r      <= pix_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

endmodule

`default_nettype wire

### src/nzmms_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nzmms_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire nzmms_pkg::in_item_t  in_payload,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire nzmms_pkg::out_item_t out_payload
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload))
    else $error("stalled output transfer changed");

  a_no_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.range_valid |-> out_payload.pixel == '0)
    else $error("pixel nonzero without a valid range");

  a_scale_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_payload.mode == nzmms_pkg::MODE_SCALE) |=> in_stall)
    else $error("input not stalled after a scale transfer");

  a_stats_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_payload.mode != nzmms_pkg::MODE_SCALE) |=> !in_stall)
    else $error("input stalled after a statistics transfer");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a scale item in work");

endmodule

bind nonzero_minmax_stretch_to_byte_unit nzmms_checker u_nzmms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_GAP = 16;
  localparam int TAIL_CYCLES = 20;
  localparam int SB = nzmms_pkg::SAMPLE_BITS;
  localparam int PB = nzmms_pkg::PIXEL_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  nzmms_pkg::in_item_t in_payload = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nzmms_pkg::out_item_t out_payload;

  logic [SB-1:0] stat_low = '1;
  logic [SB-1:0] stat_high = '0;
  bit stat_seen = 1'b0;

  nzmms_pkg::out_item_t pixel_q[$];
  nzmms_pkg::out_item_t want;
  int err_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  nonzero_minmax_stretch_to_byte_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endfunction

  // Updates the running statistics and returns 1 when the item yields a pixel.
  function automatic bit stretch_predict(input nzmms_pkg::in_item_t it,
                                         output nzmms_pkg::out_item_t res);
    logic [SB-1:0] v;
    bit has_range;
    int unsigned num;
    int unsigned den;
    v = it.sample;
    res = '0;
    case (it.mode)
      nzmms_pkg::MODE_CLEAR: begin
        stat_low = '1;
        stat_high = '0;
        stat_seen = 1'b0;
        return 1'b0;
      end
      nzmms_pkg::MODE_MEASURE: begin
        if (v != 0) begin
          if (v < stat_low) stat_low = v;
          if (v > stat_high) stat_high = v;
          stat_seen = 1'b1;
        end
        return 1'b0;
      end
      nzmms_pkg::MODE_SCALE: begin
        has_range = stat_seen && (stat_high > stat_low);
        res.range_valid = has_range;
        if (v != 0 && has_range) begin
          if (v <= stat_low) begin
            res.pixel = '0;
          end else if (v >= stat_high) begin
            res.pixel = PB'(nzmms_pkg::OUT_MAX);
          end else begin
            num = 32'(v - stat_low) * 32'(nzmms_pkg::OUT_MAX);
            den = 32'(stat_high - stat_low);
            res.pixel = PB'(num / den);
          end
        end
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [SB-1:0] sample);
    int gap;
    nzmms_pkg::in_item_t it;
    nzmms_pkg::out_item_t res;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    it.mode = mode;
    it.sample = sample;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= it;
    do @(posedge clk); while (in_stall);
    if (stretch_predict(it, res)) pixel_q.push_back(res);
    sent_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SB-1:0] near(int c);
    int t;
    t = c + int'($urandom_range(0, 4)) - 2;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return t[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] pick_sample(int lo, int hi);
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return SB'($urandom_range(0, 65535));
      3: return near(lo);
      4: return near(hi);
      default: return SB'($urandom_range(lo, hi));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        note_error($sformatf("unexpected result transfer: pixel %0d range_valid %0b",
                             out_payload.pixel, out_payload.range_valid));
      end else begin
        want = pixel_q.pop_front();
        checked_count++;
        if (want.pixel !== out_payload.pixel || want.range_valid !== out_payload.range_valid)
          note_error($sformatf("expected pixel %0d range_valid %0b, got pixel %0d range_valid %0b",
                               want.pixel, want.range_valid,
                               out_payload.pixel, out_payload.range_valid));
      end
    end
  end

  initial begin
    int hold;
    forever begin
      hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic test_no_range();
    send_item(nzmms_pkg::MODE_SCALE, 16'd0);
    send_item(nzmms_pkg::MODE_SCALE, 16'hFFFF);
    send_item(nzmms_pkg::MODE_MEASURE, 16'd0);
    send_item(nzmms_pkg::MODE_SCALE, 16'd5);
    send_item(nzmms_pkg::MODE_MEASURE, 16'd7);
    send_item(nzmms_pkg::MODE_SCALE, 16'd7);
    send_item(nzmms_pkg::MODE_SCALE, 16'd8);
  endtask

  task automatic test_extremes();
    send_item(nzmms_pkg::MODE_CLEAR, 16'hFFFF);
    send_item(nzmms_pkg::MODE_MEASURE, 16'hFFFF);
    send_item(nzmms_pkg::MODE_MEASURE, 16'd1);
    send_item(nzmms_pkg::MODE_SCALE, 16'd0);
    send_item(nzmms_pkg::MODE_SCALE, 16'd1);
    send_item(nzmms_pkg::MODE_SCALE, 16'd2);
    send_item(nzmms_pkg::MODE_SCALE, 16'h8000);
    send_item(nzmms_pkg::MODE_SCALE, 16'hFFFE);
    send_item(nzmms_pkg::MODE_SCALE, 16'hFFFF);
  endtask

  task automatic test_saturation_and_ignore();
    send_item(nzmms_pkg::MODE_CLEAR, 16'd0);
    send_item(nzmms_pkg::MODE_MEASURE, 16'd500);
    send_item(nzmms_pkg::MODE_MEASURE, 16'd400);
    send_item(nzmms_pkg::MODE_MEASURE, 16'd0);
    send_item(nzmms_pkg::MODE_SCALE, 16'd399);
    send_item(nzmms_pkg::MODE_SCALE, 16'd450);
    send_item(nzmms_pkg::MODE_SCALE, 16'd501);
    send_item(MODE_UNUSED, 16'd1);
    send_item(nzmms_pkg::MODE_SCALE, 16'd450);
  endtask

  task automatic test_drain_pause();
    send_item(nzmms_pkg::MODE_SCALE, 16'd420);
    send_item(nzmms_pkg::MODE_SCALE, 16'd480);
    wait_drained();
    send_item(nzmms_pkg::MODE_MEASURE, 16'd300);
    send_item(nzmms_pkg::MODE_SCALE, 16'd350);
  endtask

  task automatic test_random_streams(int target);
    int lo;
    int hi;
    int start;
    start = sent_count;
    while (sent_count - start < target) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(0, 3)), SB'($urandom_range(0, 65535)));
      end else begin
        if ($urandom_range(0, 7) != 0) send_item(nzmms_pkg::MODE_CLEAR, SB'($urandom));
        lo = $urandom_range(1, 65535);
        case ($urandom_range(0, 2))
          0: hi = lo + $urandom_range(0, 3);
          1: hi = lo + $urandom_range(0, 255);
          default: hi = $urandom_range(lo, 65535);
        endcase
        if (hi > 65535) hi = 65535;
        repeat ($urandom_range(1, 12))
          send_item(nzmms_pkg::MODE_MEASURE, pick_sample(lo, hi));
        repeat ($urandom_range(1, 12))
          send_item(nzmms_pkg::MODE_SCALE, pick_sample(lo, hi));
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_no_range();
    test_extremes();
    test_saturation_and_ignore();
    test_drain_pause();
    test_random_streams(920);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d input transfers and checked %0d pixel transfers.",
             sent_count, checked_count);
    $display("Ranges ran from empty and flat to full scale, with zero samples and clipping.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
src/nzmms_pkg.sv
src/nzmms_stats.sv
src/nzmms_div.sv
src/nonzero_minmax_stretch_to_byte_unit.sv
src/nzmms_checker.sv
tb/sv/tb.sv
